// ===== rtl/assert_macros.svh =====
// Assertion helpers; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ===== rtl/ptra_pkg.sv =====
package ptra_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 4096;

  localparam logic [11:0] WINDOW_START_RST = 12'd1024;
  localparam logic [12:0] WINDOW_END_RST   = 13'd4096;

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_FIND  = 3'd0;
  localparam mode_t MODE_MAP   = 3'd1;
  localparam mode_t MODE_UNMAP = 3'd2;
  localparam mode_t MODE_WRITE = 3'd3;
  localparam mode_t MODE_READ  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2,
    ST_ZERO    = 2'd3
  } status_t;

  typedef logic cfg_index_t;
  localparam cfg_index_t CFG_WINDOW_START = 1'b0;
  localparam cfg_index_t CFG_WINDOW_END   = 1'b1;

  localparam logic [31:0] PTE_UNMAPPED = 32'd2;
  localparam logic [1:0]  PTE_FLAGS    = 2'b11;
  localparam int unsigned SEARCH_GAP   = 4;

  // Packed so that mode sits in the lowest bits.
  typedef struct packed {
    logic [12:0] count;
    logic [31:0] value;
    logic [19:0] frame;
    logic [11:0] vpage;
    mode_t       mode;
  } req_t;

  typedef struct packed {
    logic [31:0] rd;
    logic [11:0] base;
    status_t     status;
  } res_t;

  function automatic logic [31:0] make_entry(input logic [19:0] frame);
    return {frame, 10'd0, PTE_FLAGS};
  endfunction

endpackage

// ===== rtl/ptra_ram.sv =====
module ptra_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/ptra_ctrl.sv =====
module ptra_ctrl
  import ptra_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_req,
  input  logic [11:0] win_start,
  input  logic [12:0] win_end,
  input  logic        start_load,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  localparam int AW = $clog2(ENTRIES);
  localparam int IW = (AW + 1 > 14) ? AW + 1 : 14;
  localparam int LW = IW + 1;
  localparam logic [IW-1:0] ENTRIES_I = IW'(ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DEC, S_SINIT, S_CHK, S_WR, S_RDW, S_DONE
  } state_t;

  state_t      state;
  req_t        op;
  logic [AW-1:0] clr_cnt;
  logic [12:0] search_pos;
  logic [IW-1:0] pos;
  logic [12:0] run;
  logic [LW-1:0] steps;
  logic [LW-1:0] limit;
  logic [IW-1:0] wr_addr;
  logic [12:0] wr_left;
  logic [19:0] wr_frame;
  logic        wr_map;
  status_t     res_status;
  logic [11:0] res_base;
  logic [31:0] res_rd;

  logic          ram_we;
  logic [IW-1:0] ram_addr_i;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  logic [IW-1:0] eff_end;
  logic [IW-1:0] start_i;
  logic [IW-1:0] count_i;
  logic [IW-1:0] vpage_i;
  logic [IW-1:0] spos_i;
  logic [IW-1:0] pos0;
  logic          vpage_ok;
  logic          free;
  logic [12:0]   run_n;
  logic [IW-1:0] pos_n;
  logic [LW-1:0] steps_n;
  logic          wrap;
  logic [IW-1:0] pos_wrap;
  logic [IW-1:0] run_base;

  always_comb begin
    eff_end  = (IW'(win_end) > ENTRIES_I) ? ENTRIES_I : IW'(win_end);
    start_i  = IW'(win_start);
    count_i  = IW'(op.count);
    vpage_i  = IW'(op.vpage);
    spos_i   = IW'(search_pos);
    pos0     = (spos_i < start_i || spos_i >= eff_end) ? start_i : spos_i;
    vpage_ok = vpage_i < ENTRIES_I;
    free     = ram_rdata[31:2] == '0;
    run_n    = free ? run + 13'd1 : '0;
    pos_n    = pos + IW'(1);
    steps_n  = steps + LW'(1);
    wrap     = pos_n >= eff_end;
    pos_wrap = wrap ? start_i : pos_n;
    run_base = pos_n - count_i;
  end

  always_comb begin
    ram_we     = 1'b0;
    ram_addr_i = '0;
    ram_wdata  = '0;
    unique case (state)
      S_CLR: begin
        ram_we     = 1'b1;
        ram_addr_i = IW'(clr_cnt);
      end
      S_DEC: begin
        ram_addr_i = vpage_i;
        ram_wdata  = op.value;
        ram_we     = op.mode == MODE_WRITE && vpage_ok;
      end
      S_SINIT: ram_addr_i = pos0;
      S_CHK:   ram_addr_i = pos_wrap;
      S_WR: begin
        ram_we     = 1'b1;
        ram_addr_i = wr_addr;
        ram_wdata  = wr_map ? make_entry(wr_frame) : PTE_UNMAPPED;
      end
      default: ram_addr_i = '0;
    endcase
  end

  ptra_ram #(
    .WIDTH (32),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr_i[AW-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      search_pos <= {1'b0, WINDOW_START_RST};
    end else begin
      if (start_load) begin
        search_pos <= {1'b0, win_start};
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op    <= in_req;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          res_status <= ST_OK;
          res_base   <= '0;
          res_rd     <= '0;
          state      <= S_DONE;
          priority if (op.mode <= MODE_UNMAP && op.count == '0) begin
            res_status <= ST_ZERO;
          end else if (op.mode == MODE_FIND) begin
            if (start_i >= eff_end || count_i > eff_end - start_i) begin
              res_status <= ST_NOSPACE;
            end else begin
              limit <= LW'(eff_end - start_i) + LW'(count_i) - LW'(1);
              state <= S_SINIT;
            end
          end else if (op.mode == MODE_MAP || op.mode == MODE_UNMAP) begin
            if (vpage_i + count_i > ENTRIES_I) begin
              res_status <= ST_RANGE;
            end else begin
              wr_addr  <= vpage_i;
              wr_left  <= op.count;
              wr_frame <= op.frame;
              wr_map   <= op.mode == MODE_MAP;
              state    <= S_WR;
            end
          end else if (op.mode == MODE_WRITE || op.mode == MODE_READ) begin
            if (!vpage_ok) begin
              res_status <= ST_RANGE;
            end else if (op.mode == MODE_READ) begin
              state <= S_RDW;
            end
          end else begin
            res_status <= ST_OK;
          end
        end
        S_SINIT: begin
          pos   <= pos0;
          run   <= '0;
          steps <= '0;
          state <= S_CHK;
        end
        S_CHK: begin
          if (run_n == op.count) begin
            res_base   <= run_base[11:0];
            search_pos <= pos_n[12:0] + 13'(SEARCH_GAP);
            wr_addr    <= run_base;
            wr_left    <= op.count;
            wr_frame   <= op.frame;
            wr_map     <= 1'b1;
            state      <= S_WR;
          end else if (steps_n == limit) begin
            res_status <= ST_NOSPACE;
            state      <= S_DONE;
          end else begin
            pos   <= pos_wrap;
            run   <= wrap ? '0 : run_n;
            steps <= steps_n;
          end
        end
        S_WR: begin
          wr_addr  <= wr_addr + IW'(1);
          wr_frame <= wr_frame + 20'd1;
          wr_left  <= wr_left - 13'd1;
          if (wr_left == 13'd1) begin
            state <= S_DONE;
          end
        end
        S_RDW: begin
          res_rd <= ram_rdata;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ready   = state == S_IDLE;
  assign res_valid  = state == S_DONE;
  assign res.status = res_status;
  assign res.base   = res_base;
  assign res.rd     = res_rd;

endmodule

// ===== rtl/page_table_run_allocator_unit.sv =====
// Channel   Dir  Handshake                  Payload
// s_        in   s_tvalid / s_tready        s_tdata: request
// m_        out  m_tvalid / m_tready        m_tdata: result
// cfg_      in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// After reset a clearing pass zeroes every table entry, with s_tready low.
// One transaction at a time; the table RAM port is walked one entry per cycle.
// Find walks at most window length + count - 1 entries; a placed run, map and unmap
// then write their count of entries; write and read touch one entry.
// Results sit in an output register; a new request is taken while it waits.
`include "assert_macros.svh"
module page_table_run_allocator_unit
  import ptra_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // mode, virtual_page, physical_frame, entry_value, page_count
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // status, base_page, read_entry, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_index_t  cfg_index,
  input  logic [12:0] cfg_data
);

  logic [11:0] window_start;
  logic [12:0] window_end;
  logic        cfg_wr;
  logic        start_load;
  logic        res_valid;
  logic        res_ready;
  res_t        res;
  res_t        out_res;

  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= WINDOW_START_RST;
      window_end   <= WINDOW_END_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_WINDOW_START: window_start <= cfg_data[11:0];
        CFG_WINDOW_END:   window_end   <= cfg_data;
        default:          window_end   <= window_end;
      endcase
    end
  end

  // search position reloads in the cycle after the write, from the updated window start
  always_ff @(posedge clk) begin
    if (rst) begin
      start_load <= 1'b0;
    end else begin
      start_load <= cfg_wr && cfg_index == CFG_WINDOW_START;
    end
  end

  ptra_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_req     (req_t'(s_tdata)),
    .win_start  (window_start),
    .win_end    (window_end),
    .start_load (start_load),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res};

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready,
    "request taken while previous one still in work")
  `ASSERT_IMPLIES(a_base_only_ok, clk, rst, m_tvalid && out_res.base != '0,
    out_res.status == ST_OK, "base page set on failed request")
  `ASSERT_IMPLIES(a_read_only_ok, clk, rst, m_tvalid && out_res.rd != '0,
    out_res.status == ST_OK && out_res.base == '0, "read data on non-read result")

endmodule

// ===== tb/page_table_run_allocator_checker.sv =====
`timescale 1ns / 100ps
module page_table_run_allocator_checker
  import ptra_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  cfg_index_t  cfg_index,
  input  logic [12:0] cfg_data,
  output int unsigned fail_count,
  output int unsigned results_owed,
  output int unsigned runs_placed,
  output int unsigned runs_refused
);

  localparam int unsigned REPORT_CAP = 50;

  logic [31:0] pte_mirror [ENTRIES];
  logic [11:0] win_lo;
  logic [12:0] win_hi;
  logic [12:0] next_fit_pos;
  res_t        owed_results[$];

  function automatic void fill_run(input int unsigned base, input int unsigned cnt,
                                   input logic [19:0] frame);
    logic [19:0] f;
    for (int unsigned i = 0; i < cnt; i++) begin
      f = frame + 20'(i);
      pte_mirror[base + i] = {f, 12'd0} | 32'(PTE_FLAGS);
    end
  endfunction

  // Applies one request to the mirrored table and returns its result.
  function automatic res_t serve_request(input req_t rq);
    res_t        r;
    int unsigned cnt, top, limit, pos, run, steps;
    r.status = ST_OK;
    r.base = '0;
    r.rd = '0;
    cnt = rq.count;
    if (rq.mode <= MODE_UNMAP && cnt == 0) begin
      r.status = ST_ZERO;
    end else begin
      case (rq.mode)
        MODE_FIND: begin
          top = (win_hi > ENTRIES) ? ENTRIES : win_hi;
          if (win_lo >= top || cnt > top - win_lo) begin
            r.status = ST_NOSPACE;
          end else begin
            // next-fit walk of at most window length + count - 1 entries
            limit = top - win_lo + cnt - 1;
            pos = next_fit_pos;
            run = 0;
            steps = 0;
            if (pos < win_lo || pos >= top) pos = win_lo;
            while (run < cnt && steps < limit) begin
              if (pos >= top) begin
                pos = win_lo;
                run = 0;
              end
              if (pte_mirror[pos][31:2] == '0) run++;
              else run = 0;
              pos++;
              steps++;
            end
            if (run < cnt) begin
              r.status = ST_NOSPACE;
            end else begin
              r.base = 12'(pos - cnt);
              fill_run(pos - cnt, cnt, rq.frame);
              next_fit_pos = 13'(pos + SEARCH_GAP);
            end
          end
        end
        MODE_MAP: begin
          if (rq.vpage + cnt > ENTRIES) r.status = ST_RANGE;
          else fill_run(rq.vpage, cnt, rq.frame);
        end
        MODE_UNMAP: begin
          if (rq.vpage + cnt > ENTRIES) begin
            r.status = ST_RANGE;
          end else begin
            for (int unsigned i = 0; i < cnt; i++) pte_mirror[rq.vpage + i] = PTE_UNMAPPED;
          end
        end
        MODE_WRITE: begin
          if (rq.vpage >= ENTRIES) r.status = ST_RANGE;
          else pte_mirror[rq.vpage] = rq.value;
        end
        MODE_READ: begin
          if (rq.vpage >= ENTRIES) r.status = ST_RANGE;
          else r.rd = pte_mirror[rq.vpage];
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    fail_count++;
    if (fail_count <= REPORT_CAP)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    req_t rq;
    if (rst) begin
      for (int unsigned i = 0; i < ENTRIES; i++) pte_mirror[i] = '0;
      win_lo = WINDOW_START_RST;
      win_hi = WINDOW_END_RST;
      next_fit_pos = {1'b0, WINDOW_START_RST};
      owed_results.delete();
    end else begin
      // retire before predicting so a result never matches a same-edge request
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[45:0]);
        if (owed_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $display("%0t: unexpected result: status %0d base %0d entry 0x%0h",
                     $time, got.status, got.base, got.rd);
        end else begin
          want = owed_results.pop_front();
          if (got.status != want.status)
            note_mismatch("status", 32'(want.status), 32'(got.status));
          if (got.base != want.base)
            note_mismatch("base_page", 32'(want.base), 32'(got.base));
          if (got.rd != want.rd)
            note_mismatch("read_entry", want.rd, got.rd);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WINDOW_START) begin
          win_lo = cfg_data[11:0];
          next_fit_pos = {1'b0, cfg_data[11:0]};
        end else begin
          win_hi = cfg_data;
        end
      end
      if (s_tvalid && s_tready) begin
        rq = req_t'(s_tdata);
        want = serve_request(rq);
        owed_results.push_back(want);
        if (rq.mode == MODE_FIND && want.status == ST_OK) runs_placed++;
        if (rq.mode == MODE_FIND && want.status == ST_NOSPACE) runs_refused++;
      end
    end
    results_owed = owed_results.size();
  end

endmodule

// ===== tb/page_table_run_allocator_unit_test.sv =====
`timescale 1ns / 100ps
module page_table_run_allocator_unit_test;
  import ptra_pkg::*;

  localparam int unsigned IDLE_LIMIT = 50000;
  localparam mode_t MODE_UNUSED_LO = 3'd5;
  localparam mode_t MODE_UNUSED_HI = 3'd7;

  typedef enum int unsigned {
    BOTH_START_FIRST,
    BOTH_END_FIRST,
    END_ONLY,
    START_ONLY
  } reg_order_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_WINDOW_START;
  logic [12:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned results_owed;
  int unsigned runs_placed;
  int unsigned runs_refused;

  int unsigned sent_by_mode [8];
  int unsigned sent_total = 0;
  int unsigned settings_used = 0;
  int unsigned cur_lo = WINDOW_START_RST;
  int unsigned cur_hi = WINDOW_END_RST;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  page_table_run_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  page_table_run_allocator_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed),
    .runs_placed  (runs_placed),
    .runs_refused (runs_refused)
  );

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t mk_req(input mode_t m, input logic [11:0] vp, input logic [19:0] fr,
                                  input logic [31:0] val, input logic [12:0] cnt);
    req_t rq;
    rq.mode = m;
    rq.vpage = vp;
    rq.frame = fr;
    rq.value = val;
    rq.count = cnt;
    return rq;
  endfunction

  function automatic req_t rand_req();
    req_t        rq;
    int unsigned r;
    int unsigned cnt;
    rq.frame = 20'($urandom);
    rq.value = $urandom_range(0, 1) ? 32'($urandom_range(0, 3)) : $urandom;
    rq.vpage = 12'($urandom);
    if (cur_hi > cur_lo && $urandom_range(0, 9) < 7)
      rq.vpage = 12'($urandom_range(cur_lo, cur_hi - 1));
    r = $urandom_range(0, 99);
    if (r < 35) rq.mode = MODE_FIND;
    else if (r < 47) rq.mode = MODE_MAP;
    else if (r < 67) rq.mode = MODE_UNMAP;
    else if (r < 77) rq.mode = MODE_WRITE;
    else if (r < 98) rq.mode = MODE_READ;
    else rq.mode = mode_t'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    // mostly short runs, rarely huge ones
    r = $urandom_range(0, 99);
    if (r < 65) cnt = $urandom_range(1, 4);
    else if (r < 93) cnt = $urandom_range(1, 32);
    else if (r < 98) cnt = $urandom_range(33, 300);
    else if (r == 98) cnt = 0;
    else cnt = $urandom_range(301, 4096);
    rq.count = 13'(cnt);
    return rq;
  endfunction

  task automatic push(input req_t rq);
    int unsigned gap;
    s_tdata <= rq;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent_by_mode[rq.mode]++;
    sent_total++;
    gap = idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [12:0] val, input bit keep);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (!keep) cfg_valid <= 1'b0;
  endtask

  task automatic reconfigure(input int unsigned lo, input int unsigned hi,
                             input reg_order_e order);
    settle();
    case (order)
      BOTH_START_FIRST: begin
        write_reg(CFG_WINDOW_START, 13'(lo), 1'b1);
        write_reg(CFG_WINDOW_END, 13'(hi), 1'b0);
      end
      BOTH_END_FIRST: begin
        write_reg(CFG_WINDOW_END, 13'(hi), 1'b1);
        write_reg(CFG_WINDOW_START, 13'(lo), 1'b0);
      end
      END_ONLY: begin
        write_reg(CFG_WINDOW_END, 13'(hi), 1'b0);
      end
      default: begin
        write_reg(CFG_WINDOW_START, 13'(lo), 1'b0);
      end
    endcase
    if (order != END_ONLY) cur_lo = lo;
    if (order != START_ONLY) cur_hi = hi;
    settings_used++;
  endtask

  task automatic random_items(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      if (k == n / 2) settle();
      push(rand_req());
    end
    calm = 1'b0;
  endtask

  initial begin
    int unsigned gap;
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = idle_len();
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned lo;
    int unsigned span;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset window: 1024 up to the table end
    push(mk_req(MODE_FIND, 12'd0, 20'd0, 32'd0, 13'd1));
    push(mk_req(MODE_FIND, 12'd0, 20'd0, 32'd0, 13'd0));
    push(mk_req(MODE_MAP, 12'd7, 20'd1, 32'd0, 13'd0));
    push(mk_req(MODE_UNMAP, 12'd7, 20'd0, 32'd0, 13'd0));
    push(mk_req(MODE_MAP, 12'hFFF, 20'hFFFFF, 32'd0, 13'd1));
    push(mk_req(MODE_READ, 12'hFFF, 20'd0, 32'd0, 13'd0));
    push(mk_req(MODE_MAP, 12'hFFF, 20'd5, 32'd0, 13'd2));
    push(mk_req(MODE_UNMAP, 12'hFFF, 20'd0, 32'd0, 13'd2));
    push(mk_req(MODE_FIND, 12'd0, 20'd9, 32'd0, 13'd4096));
    // fill the whole table, frames wrap past the top
    push(mk_req(MODE_MAP, 12'd0, 20'hFFFF0, 32'd0, 13'd4096));
    push(mk_req(MODE_FIND, 12'd0, 20'd3, 32'd0, 13'd1));
    push(mk_req(MODE_READ, 12'd2048, 20'd0, 32'd0, 13'd0));
    push(mk_req(MODE_UNMAP, 12'd0, 20'd0, 32'd0, 13'd4096));
    // flag bits alone still leave an entry free
    push(mk_req(MODE_WRITE, 12'd1030, 20'd0, 32'd3, 13'd0));
    push(mk_req(MODE_FIND, 12'd0, 20'h12345, 32'd0, 13'd3));
    push(mk_req(MODE_WRITE, 12'd0, 20'd0, 32'hFFFF_FFFF, 13'd0));
    push(mk_req(MODE_READ, 12'd0, 20'd0, 32'd0, 13'd0));
    push(mk_req(MODE_WRITE, 12'd0, 20'd0, 32'd0, 13'd0));
    for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
      push(mk_req(mode_t'(m), '1, '1, '1, '1));

    // whole table as window; first find lands on page zero
    reconfigure(0, 4096, BOTH_START_FIRST);
    push(mk_req(MODE_FIND, 12'd0, 20'd77, 32'd0, 13'd1));
    random_items(200);
    reconfigure(4095, 4096, BOTH_END_FIRST);
    random_items(60);
    // empty window
    reconfigure(4000, 1, BOTH_END_FIRST);
    random_items(60);
    repeat (5) begin
      lo = $urandom_range(0, 3968);
      span = ($urandom_range(0, 9) < 6) ? $urandom_range(16, 128) : $urandom_range(129, 600);
      if (lo + span > 4096) span = 4096 - lo;
      reconfigure(lo, lo + span, reg_order_e'($urandom_range(BOTH_START_FIRST, START_ONLY)));
      random_items(200);
    end

    settle();
    repeat (64) @(posedge clk);
    $display("Sent %0d requests (find %0d, map %0d, unmap %0d, write %0d, read %0d, other %0d)",
             sent_total, sent_by_mode[MODE_FIND], sent_by_mode[MODE_MAP],
             sent_by_mode[MODE_UNMAP], sent_by_mode[MODE_WRITE], sent_by_mode[MODE_READ],
             sent_total - sent_by_mode[MODE_FIND] - sent_by_mode[MODE_MAP]
             - sent_by_mode[MODE_UNMAP] - sent_by_mode[MODE_WRITE] - sent_by_mode[MODE_READ]);
    $display("Across %0d window settings finds placed %0d runs and were refused %0d times",
             settings_used, runs_placed, runs_refused);
    if (fail_count == 0 && results_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ptra_pkg.sv
rtl/ptra_ram.sv
rtl/ptra_ctrl.sv
rtl/page_table_run_allocator_unit.sv
tb/page_table_run_allocator_checker.sv
tb/page_table_run_allocator_unit_test.sv
